// ===== design/mmhq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmhq_pkg
// Shared types, codes and helpers of the min-max heap queue.
// ----------------------------------------------------------------------------
package mmhq_pkg;

  localparam int DATA_W       = 32;
  localparam int CAPACITY_DEF = 1024;
  localparam int CMD_W        = 2;
  localparam int STAT_W       = 2;

  localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP_MIN = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POP_MAX = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  // bits at even positions, used to find the tree level parity of a position
  localparam logic [31:0] EVEN_BITS = 32'h5555_5555;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef struct packed {
    logic  rd;
    logic  wr;
    data_t wdata;
  } mem_req_t;

  // on a min level smaller wins, on a max level larger wins
  function automatic logic better(input logic minl, input data_t a, input data_t b);
    better = minl ? (a < b) : (a > b);
  endfunction

endpackage

// ===== design/min_max_heap_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_max_heap_queue
// Double-ended priority queue of signed 32-bit values kept as a min-max heap.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; busy stays high until
// the result, which appears on the out_ ports for one cycle with out_valid and
// must be captured then. The heap is stored in a chain of level cells, one per
// tree level, and the sequencer makes at most one cell access per cycle. Clear,
// a refused insert and a pop from an empty heap go straight to the result; an
// insert reads its parent and then climbs by grandparent steps (an insert into
// an empty heap writes the root directly); a pop reads the last entry and then
// trickles down, a step reading up to six children and grandchildren.
// ----------------------------------------------------------------------------
module min_max_heap_queue #(
  parameter int CAPACITY = mmhq_pkg::CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [mmhq_pkg::CMD_W-1:0]    in_command,
  input  mmhq_pkg::data_t               in_value,
  output logic                          out_valid,
  output mmhq_pkg::data_t               out_popped_value,
  output logic [mmhq_pkg::STAT_W-1:0]   out_status,
  output logic [$clog2(CAPACITY+1)-1:0] out_entry_count,
  output mmhq_pkg::data_t               out_least_value,
  output mmhq_pkg::data_t               out_greatest_value
);

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int PW   = CW + 2;
  localparam int NLVL = CW;

  mmhq_pkg::mem_req_t req;
  logic [PW-1:0]      req_pos;
  mmhq_pkg::data_t    rd_chain [NLVL+1];

  assign rd_chain[NLVL] = '0;

  // read data walks from the deepest level toward the root cell
  for (genvar k = 0; k < NLVL; k++) begin : g_lvl
    mmhq_cell #(
      .LVL      (k),
      .CAPACITY (CAPACITY),
      .PW       (PW)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .req       (req),
      .req_pos   (req_pos),
      .chain_in  (rd_chain[k+1]),
      .chain_out (rd_chain[k])
    );
  end

  mmhq_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_command         (in_command),
    .in_value           (in_value),
    .out_valid          (out_valid),
    .out_popped_value   (out_popped_value),
    .out_status         (out_status),
    .out_entry_count    (out_entry_count),
    .out_least_value    (out_least_value),
    .out_greatest_value (out_greatest_value),
    .req                (req),
    .req_pos            (req_pos),
    .rd_data            (rd_chain[0])
  );

endmodule

// ===== design/mmhq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmhq_cell
// One tree level of the heap: owns the entries of its level and puts its
// registered read data on the return chain toward the root cell.
// ----------------------------------------------------------------------------
module mmhq_cell #(
  parameter int LVL      = 0,
  parameter int CAPACITY = mmhq_pkg::CAPACITY_DEF,
  parameter int PW       = 13
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mmhq_pkg::mem_req_t req,
  input  logic [PW-1:0]      req_pos,
  input  mmhq_pkg::data_t    chain_in,
  output mmhq_pkg::data_t    chain_out
);

  localparam int SPAN  = 1 << LVL;
  localparam int DEPTH = (CAPACITY - SPAN + 1 < SPAN) ? (CAPACITY - SPAN + 1) : SPAN;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  mmhq_pkg::data_t level_mem [DEPTH];

  logic            hit;
  logic [PW-1:0]   off;
  logic [AW-1:0]   addr;
  mmhq_pkg::data_t rd_q_r;
  logic            rd_hit_r;

  // position belongs here when its leading one sits at bit LVL
  assign hit  = (req_pos >> LVL) == PW'(1);
  assign off  = req_pos - PW'(SPAN);
  assign addr = off[AW-1:0];

  always_ff @(posedge clk) begin
    if (req.wr && hit) begin
      level_mem[addr] <= req.wdata;
    end
    if (req.rd && hit) begin
      rd_q_r <= level_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_hit_r <= 1'b0;
    end else begin
      rd_hit_r <= req.rd && hit;
    end
  end

  assign chain_out = rd_hit_r ? rd_q_r : chain_in;

endmodule

// ===== design/mmhq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmhq_ctrl
// Command sequencer: bubble-up, trickle-down and result reporting, at most one
// level-cell access per cycle.
// ----------------------------------------------------------------------------
module mmhq_ctrl #(
  parameter int CAPACITY = mmhq_pkg::CAPACITY_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [mmhq_pkg::CMD_W-1:0]         in_command,
  input  mmhq_pkg::data_t                    in_value,
  output logic                               out_valid,
  output mmhq_pkg::data_t                    out_popped_value,
  output logic [mmhq_pkg::STAT_W-1:0]        out_status,
  output logic [$clog2(CAPACITY+1)-1:0]      out_entry_count,
  output mmhq_pkg::data_t                    out_least_value,
  output mmhq_pkg::data_t                    out_greatest_value,
  output mmhq_pkg::mem_req_t                 req,
  output logic [$clog2(CAPACITY+1)+1:0]      req_pos,
  input  mmhq_pkg::data_t                    rd_data
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = CW + 2;
  localparam logic [PW-1:0] EVEN_MASK = PW'(mmhq_pkg::EVEN_BITS);

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_GR_RD,
    S_GR_CMP,
    S_POP_RD,
    S_POP_LD,
    S_SCAN,
    S_DECIDE,
    S_FIX,
    S_WR_FIN,
    S_FINISH
  } state_t;

  state_t                      state_r;
  logic [CW-1:0]               cnt_r;
  logic [PW-1:0]               hole_r;
  mmhq_pkg::data_t             cur_r;
  logic                        minl_r;
  mmhq_pkg::data_t             best_r;
  logic [PW-1:0]               mpos_r;
  mmhq_pkg::data_t             c0_r;
  mmhq_pkg::data_t             c1_r;
  logic [2:0]                  j_r;
  logic [2:0]                  pj_r;
  logic                        pend_r;
  mmhq_pkg::data_t             popped_r;
  logic [mmhq_pkg::STAT_W-1:0] status_r;
  mmhq_pkg::data_t             top1_r;
  mmhq_pkg::data_t             top2_r;
  mmhq_pkg::data_t             top3_r;
  logic                        out_valid_r;
  mmhq_pkg::data_t             out_popped_r;
  logic [mmhq_pkg::STAT_W-1:0] out_status_r;
  logic [CW-1:0]               out_count_r;
  mmhq_pkg::data_t             out_least_r;
  mmhq_pkg::data_t             out_greatest_r;

  logic [PW-1:0]   cnt_pos;
  logic [PW-1:0]   ins_pos;
  logic            ins_minl;
  mmhq_pkg::data_t max_val;
  logic [PW-1:0]   scan_pos;
  logic [PW-1:0]   pend_pos;
  logic            issue_ok;
  logic            no_child;
  logic            take;
  logic            mgrand;
  mmhq_pkg::data_t qv;
  logic            up_swap;
  logic            gr_take;
  logic [PW-1:0]   up_hole;
  logic [PW-1:0]   gr_hole;

  // children are scan steps 0 and 1, grandchildren steps 2 to 5
  function automatic logic [PW-1:0] pos_of(input logic [PW-1:0] h, input logic [2:0] j);
    logic [PW-1:0] p;
    if (j < 3'd2) begin
      p = (h << 1) + PW'(j);
    end else begin
      p = (h << 2) + PW'(j - 3'd2);
    end
    return p;
  endfunction

  assign cnt_pos  = PW'(cnt_r);
  assign ins_pos  = cnt_pos + PW'(1);
  assign ins_minl = (ins_pos & EVEN_MASK) > (ins_pos & ~EVEN_MASK);
  assign scan_pos = pos_of(hole_r, j_r);
  assign pend_pos = pos_of(hole_r, pj_r);
  assign issue_ok = (j_r < 3'd6) && (scan_pos <= cnt_pos);
  assign no_child = (hole_r << 1) > cnt_pos;
  assign take     = mmhq_pkg::better(minl_r, best_r, cur_r);
  assign mgrand   = mpos_r >= (hole_r << 2);
  assign qv       = mpos_r[1] ? c1_r : c0_r;
  assign up_swap  = mmhq_pkg::better(~minl_r, cur_r, rd_data);
  assign gr_take  = mmhq_pkg::better(minl_r, cur_r, rd_data);
  assign up_hole  = up_swap ? (hole_r >> 1) : hole_r;
  assign gr_hole  = hole_r >> 2;

  always_comb begin
    if (cnt_r == '0) begin
      max_val = '0;
    end else if (cnt_r == CW'(1)) begin
      max_val = top1_r;
    end else if (cnt_r == CW'(2)) begin
      max_val = top2_r;
    end else begin
      max_val = (top2_r > top3_r) ? top2_r : top3_r;
    end
  end

  always_comb begin
    req     = '0;
    req_pos = '0;
    unique case (state_r)
      S_UP_RD: begin
        req.rd  = 1'b1;
        req_pos = hole_r >> 1;
      end
      S_UP_CMP: begin
        if (up_swap) begin
          req.wr    = 1'b1;
          req.wdata = rd_data;
          req_pos   = hole_r;
        end
      end
      S_GR_RD: begin
        req.rd  = 1'b1;
        req_pos = gr_hole;
      end
      S_GR_CMP: begin
        if (gr_take) begin
          req.wr    = 1'b1;
          req.wdata = rd_data;
          req_pos   = hole_r;
        end
      end
      S_POP_RD: begin
        req.rd  = 1'b1;
        req_pos = ins_pos;
      end
      S_SCAN: begin
        if (issue_ok) begin
          req.rd  = 1'b1;
          req_pos = scan_pos;
        end
      end
      S_DECIDE: begin
        if (!no_child && take) begin
          req.wr    = 1'b1;
          req.wdata = best_r;
          req_pos   = hole_r;
        end
      end
      S_FIX: begin
        req.wr    = 1'b1;
        req.wdata = cur_r;
        req_pos   = mpos_r >> 1;
      end
      S_WR_FIN: begin
        req.wr    = 1'b1;
        req.wdata = cur_r;
        req_pos   = hole_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      j_r         <= '0;
    end else begin
      out_valid_r <= 1'b0;
      // mirror of the three top entries for pops and min/max reporting
      if (req.wr) begin
        if (req_pos == PW'(1)) top1_r <= req.wdata;
        if (req_pos == PW'(2)) top2_r <= req.wdata;
        if (req_pos == PW'(3)) top3_r <= req.wdata;
      end
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            popped_r <= '0;
            status_r <= mmhq_pkg::ST_OK;
            unique case (in_command)
              mmhq_pkg::CMD_INSERT: begin
                if (cnt_r == CW'(CAPACITY)) begin
                  status_r <= mmhq_pkg::ST_FULL;
                  state_r  <= S_FINISH;
                end else begin
                  cnt_r   <= cnt_r + CW'(1);
                  hole_r  <= ins_pos;
                  cur_r   <= in_value;
                  minl_r  <= ins_minl;
                  state_r <= (cnt_r == '0) ? S_WR_FIN : S_UP_RD;
                end
              end
              mmhq_pkg::CMD_POP_MIN, mmhq_pkg::CMD_POP_MAX: begin
                if (cnt_r == '0) begin
                  status_r <= mmhq_pkg::ST_EMPTY;
                  state_r  <= S_FINISH;
                end else begin
                  cnt_r   <= cnt_r - CW'(1);
                  state_r <= S_POP_RD;
                  if (in_command == mmhq_pkg::CMD_POP_MIN || cnt_r == CW'(1)) begin
                    popped_r <= top1_r;
                    hole_r   <= PW'(1);
                    minl_r   <= 1'b1;
                  end else begin
                    popped_r <= max_val;
                    minl_r   <= 1'b0;
                    if (cnt_r == CW'(2) || top2_r > top3_r) begin
                      hole_r <= PW'(2);
                    end else begin
                      hole_r <= PW'(3);
                    end
                  end
                end
              end
              mmhq_pkg::CMD_CLEAR: begin
                cnt_r   <= '0;
                state_r <= S_FINISH;
              end
              default: state_r <= S_FINISH;
            endcase
          end
        end
        S_UP_RD: state_r <= S_UP_CMP;
        S_UP_CMP: begin
          hole_r <= up_hole;
          if (up_swap) minl_r <= ~minl_r;
          state_r <= (up_hole >= PW'(4)) ? S_GR_RD : S_WR_FIN;
        end
        S_GR_RD: state_r <= S_GR_CMP;
        S_GR_CMP: begin
          if (gr_take) begin
            hole_r  <= gr_hole;
            state_r <= (gr_hole >= PW'(4)) ? S_GR_RD : S_WR_FIN;
          end else begin
            state_r <= S_WR_FIN;
          end
        end
        S_POP_RD: state_r <= S_POP_LD;
        S_POP_LD: begin
          cur_r   <= rd_data;
          j_r     <= '0;
          pend_r  <= 1'b0;
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          if (issue_ok) begin
            j_r  <= j_r + 3'd1;
            pj_r <= j_r;
          end
          pend_r <= issue_ok;
          if (pend_r) begin
            if (pj_r == 3'd0) c0_r <= rd_data;
            if (pj_r == 3'd1) c1_r <= rd_data;
            // first child opens the search, later ones must be strictly better
            if (pj_r == 3'd0 || mmhq_pkg::better(minl_r, rd_data, best_r)) begin
              best_r <= rd_data;
              mpos_r <= pend_pos;
            end
          end
          if (!issue_ok && !pend_r) state_r <= S_DECIDE;
        end
        S_DECIDE: begin
          if (no_child || !take) begin
            state_r <= S_WR_FIN;
          end else begin
            hole_r <= mpos_r;
            if (!mgrand) begin
              state_r <= S_WR_FIN;
            end else if (mmhq_pkg::better(minl_r, qv, cur_r)) begin
              state_r <= S_FIX;
            end else begin
              j_r     <= '0;
              pend_r  <= 1'b0;
              state_r <= S_SCAN;
            end
          end
        end
        S_FIX: begin
          // parent of the grandchild took the moving item, carry its value on
          cur_r   <= qv;
          j_r     <= '0;
          pend_r  <= 1'b0;
          state_r <= S_SCAN;
        end
        S_WR_FIN: state_r <= S_FINISH;
        S_FINISH: begin
          out_valid_r    <= 1'b1;
          out_popped_r   <= popped_r;
          out_status_r   <= status_r;
          out_count_r    <= cnt_r;
          out_least_r    <= (cnt_r == '0) ? '0 : top1_r;
          out_greatest_r <= max_val;
          state_r        <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy               = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_popped_value   = out_popped_r;
  assign out_status         = out_status_r;
  assign out_entry_count    = out_count_r;
  assign out_least_value    = out_least_r;
  assign out_greatest_value = out_greatest_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not make the block busy");

  a_finish_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH) |=> (out_valid && !busy))
    else $error("finish did not produce a result");

  a_read_range: assert property (@(posedge clk) disable iff (!rst_n)
    req.rd |-> ((req_pos != '0) && (req_pos <= PW'(CAPACITY))))
    else $error("read outside the heap");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == mmhq_pkg::ST_FULL) |-> (out_entry_count == CW'(CAPACITY)))
    else $error("full status with heap not full");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == mmhq_pkg::ST_EMPTY)
      |-> (out_entry_count == '0 && out_popped_value == '0))
    else $error("empty status with entries present");

endmodule

// ===== tb/sv/min_max_heap_queue_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_max_heap_queue_tb
// Self-checking bench for the min-max heap queue. A scoreboard keeps its own
// min-max heap, predicts every result from the accepted commands and compares
// it field by field. Directed cases come first, then random mixes with sender
// idling, a fill to capacity and churn around the full mark.
// ----------------------------------------------------------------------------

typedef struct {
  mmhq_pkg::data_t             popped;
  logic [mmhq_pkg::STAT_W-1:0] status;
  logic [10:0]                 count;
  mmhq_pkg::data_t             least;
  mmhq_pkg::data_t             greatest;
} heap_result_t;

class heap_scoreboard;
  mmhq_pkg::data_t heap_mem[mmhq_pkg::CAPACITY_DEF];
  int unsigned     cnt;
  heap_result_t    pending_results[$];
  int              failures;

  function new();
    cnt      = 0;
    failures = 0;
  endfunction

  function bit on_min_row(int unsigned idx);
    int unsigned n;
    int unsigned lvl;
    n   = idx + 1;
    lvl = 0;
    while (n > 1) begin
      n = n >> 1;
      lvl++;
    end
    return lvl[0] == 1'b0;
  endfunction

  // smaller wins on min rows, larger on max rows
  function bit outranks(bit minl, mmhq_pkg::data_t a, mmhq_pkg::data_t b);
    return minl ? (a < b) : (a > b);
  endfunction

  function void swap_slots(int unsigned a, int unsigned b);
    mmhq_pkg::data_t t;
    t           = heap_mem[a];
    heap_mem[a] = heap_mem[b];
    heap_mem[b] = t;
  endfunction

  function int unsigned top_slot();
    if (cnt <= 1) return 0;
    if (cnt == 2) return 1;
    return (heap_mem[1] > heap_mem[2]) ? 1 : 2;
  endfunction

  function void trickle_down(int unsigned start_idx);
    int unsigned i;
    int unsigned first;
    int unsigned m;
    int unsigned k;
    int unsigned p;
    bit          minl;
    bit          done;
    i    = start_idx;
    minl = on_min_row(i);
    done = 1'b0;
    while (!done) begin
      first = 2 * i + 1;
      m     = first;
      if (first >= cnt) begin
        done = 1'b1;
      end else begin
        if (2 * i + 2 < cnt && outranks(minl, heap_mem[2 * i + 2], heap_mem[m])) m = 2 * i + 2;
        for (k = 4 * i + 3; k <= 4 * i + 6; k++) begin
          if (k < cnt && outranks(minl, heap_mem[k], heap_mem[m])) m = k;
        end
        if (m >= 4 * i + 3) begin
          // grandchild won: swap, then repair against its parent
          if (!outranks(minl, heap_mem[m], heap_mem[i])) begin
            done = 1'b1;
          end else begin
            swap_slots(i, m);
            p = (m - 1) / 2;
            if (outranks(minl, heap_mem[p], heap_mem[m])) swap_slots(m, p);
            i = m;
          end
        end else begin
          if (outranks(minl, heap_mem[m], heap_mem[i])) swap_slots(i, m);
          done = 1'b1;
        end
      end
    end
  endfunction

  function void climb_grand(int unsigned start_idx, bit minl);
    int unsigned i;
    int unsigned g;
    i = start_idx;
    while (i >= 3) begin
      g = (i - 3) / 4;
      if (!outranks(minl, heap_mem[i], heap_mem[g])) break;
      swap_slots(i, g);
      i = g;
    end
  endfunction

  function void bubble_up(int unsigned i);
    int unsigned p;
    if (i < 1) return;
    p = (i - 1) / 2;
    if (on_min_row(i)) begin
      if (heap_mem[i] > heap_mem[p]) begin
        swap_slots(i, p);
        climb_grand(p, 1'b0);
      end else begin
        climb_grand(i, 1'b1);
      end
    end else begin
      if (heap_mem[i] < heap_mem[p]) begin
        swap_slots(i, p);
        climb_grand(p, 1'b1);
      end else begin
        climb_grand(i, 1'b0);
      end
    end
  endfunction

  function void note_command(logic [mmhq_pkg::CMD_W-1:0] cmd, mmhq_pkg::data_t val);
    heap_result_t r;
    int unsigned  slot;
    r.popped = '0;
    r.status = mmhq_pkg::ST_OK;
    case (cmd)
      mmhq_pkg::CMD_INSERT: begin
        if (cnt >= mmhq_pkg::CAPACITY_DEF) begin
          r.status = mmhq_pkg::ST_FULL;
        end else begin
          heap_mem[cnt] = val;
          bubble_up(cnt);
          cnt++;
        end
      end
      mmhq_pkg::CMD_POP_MIN, mmhq_pkg::CMD_POP_MAX: begin
        if (cnt == 0) begin
          r.status = mmhq_pkg::ST_EMPTY;
        end else begin
          slot           = (cmd == mmhq_pkg::CMD_POP_MIN) ? 0 : top_slot();
          r.popped       = heap_mem[slot];
          cnt--;
          heap_mem[slot] = heap_mem[cnt];
          trickle_down(slot);
        end
      end
      default: begin
        cnt = 0;
      end
    endcase
    r.count    = 11'(cnt);
    r.least    = (cnt != 0) ? heap_mem[0] : '0;
    r.greatest = (cnt != 0) ? heap_mem[top_slot()] : '0;
    pending_results.push_back(r);
  endfunction

  function void check_result(mmhq_pkg::data_t popped,
                             logic [mmhq_pkg::STAT_W-1:0] status,
                             logic [10:0] count,
                             mmhq_pkg::data_t least, mmhq_pkg::data_t greatest);
    heap_result_t e;
    if (pending_results.size() == 0) begin
      $error("result with no command outstanding: popped %0d status %0d count %0d",
             popped, status, count);
      failures++;
      return;
    end
    e = pending_results.pop_front();
    if (popped !== e.popped) begin
      $error("popped_value expected %0d actual %0d", e.popped, popped);
      failures++;
    end
    if (status !== e.status) begin
      $error("status expected %0d actual %0d", e.status, status);
      failures++;
    end
    if (count !== e.count) begin
      $error("entry_count expected %0d actual %0d", e.count, count);
      failures++;
    end
    if (least !== e.least) begin
      $error("least_value expected %0d actual %0d", e.least, least);
      failures++;
    end
    if (greatest !== e.greatest) begin
      $error("greatest_value expected %0d actual %0d", e.greatest, greatest);
      failures++;
    end
  endfunction
endclass

module min_max_heap_queue_tb;
  localparam int CAP = mmhq_pkg::CAPACITY_DEF;

  logic                        clk;
  logic                        rst_n;
  logic                        start;
  logic                        busy;
  logic [mmhq_pkg::CMD_W-1:0]  in_command;
  mmhq_pkg::data_t             in_value;
  logic                        out_valid;
  mmhq_pkg::data_t             out_popped_value;
  logic [mmhq_pkg::STAT_W-1:0] out_status;
  logic [10:0]                 out_entry_count;
  mmhq_pkg::data_t             out_least_value;
  mmhq_pkg::data_t             out_greatest_value;

  heap_scoreboard sb;

  min_max_heap_queue u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_command         (in_command),
    .in_value           (in_value),
    .out_valid          (out_valid),
    .out_popped_value   (out_popped_value),
    .out_status         (out_status),
    .out_entry_count    (out_entry_count),
    .out_least_value    (out_least_value),
    .out_greatest_value (out_greatest_value)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      sb.check_result(out_popped_value, out_status, out_entry_count, out_least_value,
                      out_greatest_value);
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_command(input logic [mmhq_pkg::CMD_W-1:0] cmd,
                              input mmhq_pkg::data_t val, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start      <= 1'b1;
    in_command <= cmd;
    in_value   <= val;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sb.note_command(cmd, val);
    @(negedge clk);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic mmhq_pkg::data_t pick_value();
    int tmp;
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        // narrow range so ties show up often
        tmp = int'($urandom_range(16)) - 8;
        return mmhq_pkg::data_t'(tmp);
      end
      4: begin
        case ($urandom_range(3))
          0:       return 32'sh7fff_ffff;
          1:       return 32'sh8000_0000;
          2:       return 32'sh0000_0000;
          default: return 32'shffff_ffff;
        endcase
      end
      default: return mmhq_pkg::data_t'($urandom);
    endcase
  endfunction

  function automatic logic [mmhq_pkg::CMD_W-1:0] pick_command(int ins_pct, bit allow_clear);
    int r;
    r = $urandom_range(99);
    if (r < ins_pct) return mmhq_pkg::CMD_INSERT;
    if (allow_clear && r >= 98) return mmhq_pkg::CMD_CLEAR;
    return r[0] ? mmhq_pkg::CMD_POP_MIN : mmhq_pkg::CMD_POP_MAX;
  endfunction

  task automatic run_mixed(input int n, input int idle_pct, input int ins_pct,
                           input bit allow_clear);
    logic [mmhq_pkg::CMD_W-1:0] cmd;
    for (int i = 0; i < n; i++) begin
      cmd = pick_command(ins_pct, allow_clear);
      send_command(cmd,
                   (cmd == mmhq_pkg::CMD_INSERT) ? pick_value()
                                                 : mmhq_pkg::data_t'($urandom),
                   idle_pct);
      if ($urandom_range(63) == 0) drain_results();
    end
  endtask

  initial begin
    sb         = new();
    rst_n      = 1'b0;
    start      = 1'b0;
    in_command = mmhq_pkg::CMD_INSERT;
    in_value   = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty heap: both pops refused, clear is harmless
    send_command(mmhq_pkg::CMD_POP_MIN, 32'sh1234_5678, 0);
    send_command(mmhq_pkg::CMD_POP_MAX, 32'shedcb_a987, 0);
    send_command(mmhq_pkg::CMD_CLEAR, 32'sh0, 0);
    // single entry: maximum sits at the root
    send_command(mmhq_pkg::CMD_INSERT, 32'sh7fff_ffff, 0);
    send_command(mmhq_pkg::CMD_POP_MAX, 32'sh0, 0);
    // two entries: maximum sits at entry 1
    send_command(mmhq_pkg::CMD_INSERT, 32'sh8000_0000, 0);
    send_command(mmhq_pkg::CMD_INSERT, 32'sh7fff_ffff, 0);
    send_command(mmhq_pkg::CMD_POP_MAX, 32'shffff_ffff, 0);
    send_command(mmhq_pkg::CMD_INSERT, 32'sh5, 0);
    send_command(mmhq_pkg::CMD_INSERT, 32'sh5, 0);
    send_command(mmhq_pkg::CMD_INSERT, 32'sh5, 0);
    send_command(mmhq_pkg::CMD_INSERT, 32'shffff_ffff, 0);
    send_command(mmhq_pkg::CMD_INSERT, 32'sh0, 0);
    send_command(mmhq_pkg::CMD_POP_MAX, 32'sh0, 0);
    send_command(mmhq_pkg::CMD_POP_MIN, 32'sh0, 0);
    send_command(mmhq_pkg::CMD_POP_MIN, 32'sh0, 0);
    send_command(mmhq_pkg::CMD_CLEAR, 32'shffff_ffff, 0);
    // equal entries 1 and 2: tie goes to entry 2
    send_command(mmhq_pkg::CMD_INSERT, 32'sh5, 0);
    send_command(mmhq_pkg::CMD_INSERT, 32'sh5, 0);
    send_command(mmhq_pkg::CMD_INSERT, 32'sh5, 0);
    send_command(mmhq_pkg::CMD_POP_MAX, 32'sh0, 0);
    send_command(mmhq_pkg::CMD_POP_MIN, 32'sh0, 0);
    send_command(mmhq_pkg::CMD_CLEAR, 32'sh0, 0);
    drain_results();

    run_mixed(350, 0, 60, 1'b1);
    drain_results();
    run_mixed(250, 80, 60, 1'b1);
    drain_results();

    // fill to capacity, then a few refused inserts
    send_command(mmhq_pkg::CMD_CLEAR, mmhq_pkg::data_t'($urandom), 26);
    while (sb.cnt < CAP) send_command(mmhq_pkg::CMD_INSERT, pick_value(), 26);
    repeat (6) send_command(mmhq_pkg::CMD_INSERT, pick_value(), 26);
    drain_results();

    // churn around the full mark
    run_mixed(200, 26, 50, 1'b0);
    drain_results();

    repeat (80) @(posedge clk);
    if (sb.failures == 0 && sb.pending_results.size() == 0) begin
      $display("min_max_heap_queue verification clean");
    end else begin
      $display("min_max_heap_queue verification failed");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("min_max_heap_queue verification failed");
    $finish;
  end
endmodule

// ===== filelist.f =====
design/mmhq_pkg.sv
design/mmhq_cell.sv
design/mmhq_ctrl.sv
design/min_max_heap_queue.sv
tb/sv/min_max_heap_queue_tb.sv
